// File: src/vfmd_pkg.sv
// Package with the fixed-point constants shared by the void fraction core and its checker.
`timescale 1ns / 1ps

package vfmd_pkg;

    // Fraction format of the void and quality values.
    localparam int FRAC_BITS = 16;
    localparam logic [16:0] ONE_F     = 17'd65536;
    localparam logic [16:0] HALF_F    = 17'd32768;
    localparam logic [16:0] VOID_HIGH = 17'd65535;
    localparam logic [16:0] QUARTER_F = 17'd16384;

    // Physical constants, rounded to nearest.
    localparam logic [19:0] GRAV_Q16 = 20'd642689;
    localparam logic [16:0] K118_Q16 = 17'd77332;
    localparam logic [16:0] K153_Q16 = 17'd100270;
    localparam logic [16:0] K012     = 17'd7864;
    localparam logic [16:0] K008     = 17'd5243;
    localparam logic [16:0] K020     = 17'd13107;
    localparam logic [16:0] K115     = 17'd75366;

    // Convergence tolerance of the bisection, at least one LSB.
    localparam logic signed [19:0] BISECT_TOL = 20'sd1;

    // Configuration register indexes.
    localparam logic [1:0] REG_HEIGHT   = 2'd0;
    localparam logic [1:0] REG_LENGTH   = 2'd1;
    localparam logic [1:0] REG_DIAMETER = 2'd2;
    localparam logic [1:0] REG_MASSVEL  = 2'd3;

    // Largest value the void fraction output can carry.
    localparam logic [16:0] VOID_MAX_OUT = 17'd65536;

endpackage

// File: src/void_fraction_mixture_density_core.sv
// Void fraction and mixture density core built around one shared divider, root and multiplier.
`timescale 1ns / 1ps

// An item is taken when start is high and busy is low; its result appears on the result ports
// with done high for exactly one cycle and must be captured then, since the receiver cannot
// stall the core. A zero quality finishes without leaving idle. Otherwise the work runs on the
// shared restoring divider (one quotient bit per cycle) and the shared square root unit (one root
// bit per cycle), which every division and root of an item passes through in turn.
module void_fraction_mixture_density_core #(
    parameter int BISECT_STEPS = 50
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [24:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [16:0] quality,
    input  logic [19:0] water_density,
    input  logic [19:0] steam_density,
    input  logic [23:0] surface_tension,
    output logic        done,
    output logic [16:0] void_fraction,
    output logic [19:0] mixture_density,
    output logic        used_homogeneous
);
    import vfmd_pkg::*;

    localparam int STEP_W = $clog2(BISECT_STEPS + 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(BISECT_STEPS);

    // Sequencer state codes.
    localparam logic [5:0] S_IDLE  = 6'd0;
    localparam logic [5:0] S_NUM   = 6'd1;
    localparam logic [5:0] S_DEN   = 6'd2;
    localparam logic [5:0] S_AHL   = 6'd3;
    localparam logic [5:0] S_AHW   = 6'd4;
    localparam logic [5:0] S_UGM   = 6'd5;
    localparam logic [5:0] S_UGL   = 6'd6;
    localparam logic [5:0] S_UGW   = 6'd7;
    localparam logic [5:0] S_SGG   = 6'd8;
    localparam logic [5:0] S_SGD   = 6'd9;
    localparam logic [5:0] S_S2L   = 6'd10;
    localparam logic [5:0] S_S2W   = 6'd11;
    localparam logic [5:0] S_S2DL  = 6'd12;
    localparam logic [5:0] S_S2DW  = 6'd13;
    localparam logic [5:0] S_S2RL  = 6'd14;
    localparam logic [5:0] S_S2RW  = 6'd15;
    localparam logic [5:0] S_AFL   = 6'd16;
    localparam logic [5:0] S_AFW   = 6'd17;
    localparam logic [5:0] S_K     = 6'd18;
    localparam logic [5:0] S_S1M   = 6'd19;
    localparam logic [5:0] S_S1L   = 6'd20;
    localparam logic [5:0] S_S1W   = 6'd21;
    localparam logic [5:0] S_S1P   = 6'd22;
    localparam logic [5:0] S_S1DL  = 6'd23;
    localparam logic [5:0] S_S1DW  = 6'd24;
    localparam logic [5:0] S_S1RL  = 6'd25;
    localparam logic [5:0] S_S1RW  = 6'd26;
    localparam logic [5:0] S_C0A   = 6'd27;
    localparam logic [5:0] S_C0B   = 6'd28;
    localparam logic [5:0] S_VRA   = 6'd29;
    localparam logic [5:0] S_VRB   = 6'd30;
    localparam logic [5:0] S_TM    = 6'd31;
    localparam logic [5:0] S_TL    = 6'd32;
    localparam logic [5:0] S_TW    = 6'd33;
    localparam logic [5:0] S_AL    = 6'd34;
    localparam logic [5:0] S_AW    = 6'd35;
    localparam logic [5:0] S_C0S   = 6'd36;
    localparam logic [5:0] S_CLAMP = 6'd37;
    localparam logic [5:0] S_HRL   = 6'd38;
    localparam logic [5:0] S_HRW   = 6'd39;
    localparam logic [5:0] S_BM    = 6'd40;
    localparam logic [5:0] S_BB    = 6'd41;
    localparam logic [5:0] S_BC    = 6'd42;
    localparam logic [5:0] S_BD    = 6'd43;
    localparam logic [5:0] S_BTL   = 6'd44;
    localparam logic [5:0] S_BTW   = 6'd45;
    localparam logic [5:0] S_BGL   = 6'd46;
    localparam logic [5:0] S_BGW   = 6'd47;
    localparam logic [5:0] S_BCHK  = 6'd48;
    localparam logic [5:0] S_FIN   = 6'd49;
    localparam logic [5:0] S_DM1   = 6'd50;
    localparam logic [5:0] S_DM2   = 6'd51;

    // Configuration registers.
    logic signed [24:0] height_reg;
    logic [23:0]        length_reg;
    logic [23:0]        diam_reg;
    logic [23:0]        massvel_reg;

    // Sequencer and result control.
    logic [5:0]        state_reg;
    logic [5:0]        state_next;
    logic              done_reg;
    logic              second_reg;
    logic [STEP_W-1:0] step_reg;

    // Item operands and intermediate values.
    logic [16:0]        x_reg;
    logic [19:0]        rw_reg;
    logic [19:0]        rs_reg;
    logic [23:0]        sig_reg;
    logic [37:0]        num_reg;
    logic [37:0]        den_reg;
    logic [16:0]        ah_reg;
    logic [40:0]        usg_reg;
    logic [27:0]        s2_reg;
    logic [16:0]        ratio_reg;
    logic [16:0]        k_reg;
    logic [27:0]        s1_reg;
    logic [26:0]        c0_reg;
    logic [26:0]        vr_reg;
    logic [43:0]        t_reg;
    logic [16:0]        a_reg;
    logic [63:0]        acc_reg;
    logic [16:0]        lo_reg;
    logic [16:0]        hi_reg;
    logic [16:0]        m_reg;
    logic signed [18:0] av_reg;
    logic [16:0]        afin_reg;
    logic               flag_reg;

    // Result registers.
    logic [16:0] void_out_reg;
    logic [19:0] dens_out_reg;
    logic        homog_out_reg;

    // Shared divider.
    logic        div_go;
    logic [63:0] div_num;
    logic [63:0] div_den;
    logic [6:0]  div_bits;
    logic [6:0]  div_cnt_reg;
    logic [63:0] div_dq_reg;
    logic [63:0] div_rem_reg;
    logic [63:0] div_dvs_reg;
    logic [63:0] div_rem_sh;
    logic        div_qbit;

    // Shared square root unit.
    logic        sq_go;
    logic [63:0] sq_val;
    logic [5:0]  sq_pairs;
    logic [5:0]  sq_cnt_reg;
    logic [63:0] sq_val_reg;
    logic [34:0] sq_rem_reg;
    logic [31:0] sq_root_reg;
    logic [34:0] sq_rem_sh;
    logic [34:0] sq_trial;
    logic        sq_take;

    // Shared multiplier.
    logic [39:0] mul_a;
    logic [27:0] mul_b;
    logic [67:0] prod;

    // Derived operands.
    logic [23:0] len_eff;
    logic [23:0] dia_eff;
    logic [23:0] gm_eff;
    logic [16:0] x_in;
    logic [19:0] rw_in;
    logic [19:0] rs_in;
    logic [19:0] drho;
    logic [25:0] h2;
    logic [24:0] hmag;
    logic [16:0] one_minus_x;
    logic [17:0] lo_hi_sum;
    logic [16:0] m_now;
    logic [16:0] a_lo_clamp;
    logic [16:0] a_clamp;
    logic signed [19:0] diff;
    logic [44:0] c0_plus_t;
    logic        item_taken;

    assign len_eff     = (length_reg == 24'd0) ? 24'd1 : length_reg;
    assign dia_eff     = (diam_reg == 24'd0) ? 24'd1 : diam_reg;
    assign gm_eff      = (massvel_reg == 24'd0) ? 24'd1 : massvel_reg;
    assign x_in        = (quality > ONE_F) ? ONE_F : quality;
    assign rw_in       = (water_density == 20'd0) ? 20'd1 : water_density;
    assign rs_in       = (steam_density == 20'd0) ? 20'd1 : steam_density;
    assign drho        = (rw_reg > rs_reg) ? (rw_reg - rs_reg) : 20'd0;
    assign h2          = {height_reg[24:0], 1'b0};
    assign hmag        = 25'(-height_reg);
    assign one_minus_x = ONE_F - x_reg;
    assign lo_hi_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign m_now       = lo_hi_sum[17:1];
    assign a_lo_clamp  = (a_reg < x_reg) ? x_reg : a_reg;
    assign a_clamp     = (a_lo_clamp > ah_reg) ? ah_reg : a_lo_clamp;
    assign diff        = signed'({3'b000, m_reg}) - 20'(av_reg);
    assign c0_plus_t   = 45'(c0_reg) + 45'(t_reg);
    assign item_taken  = start && !busy;

    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;
    assign void_fraction    = void_out_reg;
    assign mixture_density  = dens_out_reg;
    assign used_homogeneous = homog_out_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg  <= 25'sd0;
            length_reg  <= 24'd65536;
            diam_reg    <= 24'd838861;
            massvel_reg <= 24'd256000;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_HEIGHT:   height_reg  <= signed'(cfg_data);
                REG_LENGTH:   length_reg  <= cfg_data[23:0];
                REG_DIAMETER: diam_reg    <= cfg_data[23:0];
                REG_MASSVEL:  massvel_reg <= cfg_data[23:0];
                default:      ;
            endcase
        end
    end

    // Shared multiplier, operands chosen by the sequencer.
    always_comb
    begin
        mul_a = 40'd0;
        mul_b = 28'd0;
        case (state_reg)
            S_NUM:   begin mul_a = 40'(rw_reg);          mul_b = 28'(x_reg);       end
            S_DEN:   begin mul_a = 40'(rs_reg);          mul_b = 28'(one_minus_x); end
            S_UGM:   begin mul_a = 40'(x_reg);           mul_b = 28'(gm_eff);      end
            S_SGG:   begin mul_a = 40'(sig_reg);         mul_b = 28'(GRAV_Q16);    end
            S_SGD:   begin mul_a = acc_reg[39:0];        mul_b = 28'(drho);        end
            S_K:     begin mul_a = 40'(K008);            mul_b = 28'(ratio_reg);   end
            S_S1M:   begin mul_a = 40'(dia_eff);         mul_b = 28'(GRAV_Q16);    end
            S_S1P:   begin mul_a = 40'(rw_reg);          mul_b = s1_reg;           end
            S_C0A:   begin mul_a = 40'(k_reg);           mul_b = 28'(one_minus_x); end
            S_C0B:   begin mul_a = acc_reg[39:0];        mul_b = s1_reg;           end
            S_VRA:   begin mul_a = 40'(s2_reg);          mul_b = 28'(one_minus_x); end
            S_VRB:   begin mul_a = acc_reg[39:0];        mul_b = 28'(K118_Q16);    end
            S_TM:    begin mul_a = 40'(vr_reg);          mul_b = 28'(ah_reg);      end
            S_C0S:   begin mul_a = 40'(K020);            mul_b = 28'(one_minus_x); end
            S_BM:    begin mul_a = 40'(s2_reg);          mul_b = 28'(ONE_F - m_now); end
            S_BB:    begin mul_a = acc_reg[39:0];        mul_b = 28'(ratio_reg);   end
            S_BC:    begin mul_a = acc_reg[39:0];        mul_b = 28'(K153_Q16);    end
            S_BD:    begin mul_a = 40'(vr_reg);          mul_b = 28'(ah_reg);      end
            S_DM1:   begin mul_a = 40'(rw_reg);          mul_b = 28'(ONE_F - afin_reg); end
            S_DM2:   begin mul_a = 40'(rs_reg);          mul_b = 28'(afin_reg);    end
            default: ;
        endcase
    end

    assign prod = 68'(mul_a) * 68'(mul_b);

    // Divider and root launches, with the dividend and radicand widths each step needs.
    always_comb
    begin
        div_go   = 1'b0;
        div_num  = 64'd0;
        div_den  = 64'd1;
        div_bits = 7'd64;
        sq_go    = 1'b0;
        sq_val   = 64'd0;
        sq_pairs = 6'd32;
        case (state_reg)
            S_AHL:
            begin
                div_go = 1'b1; div_num = 64'(num_reg) << FRAC_BITS;
                div_den = 64'(den_reg); div_bits = 7'd54;
            end
            S_UGL:
            begin
                div_go = 1'b1; div_num = acc_reg; div_den = 64'(rs_reg); div_bits = 7'd41;
            end
            S_S2L:
            begin
                sq_go = 1'b1; sq_val = acc_reg; sq_pairs = 6'd28;
            end
            S_S2DL:
            begin
                div_go = 1'b1; div_num = 64'(s2_reg) << 20;
                div_den = 64'(rw_reg); div_bits = 7'd49;
            end
            S_S2RL:
            begin
                sq_go = 1'b1; sq_val = acc_reg; sq_pairs = 6'd24;
            end
            S_AFL:
            begin
                div_go = (26'(len_eff) > h2); div_num = 64'(h2) << FRAC_BITS;
                div_den = 64'(len_eff); div_bits = 7'd41;
            end
            S_S1L:
            begin
                sq_go = 1'b1; sq_val = acc_reg; sq_pairs = 6'd22;
            end
            S_S1DL:
            begin
                div_go = 1'b1; div_num = acc_reg; div_den = 64'(gm_eff); div_bits = 7'd54;
            end
            S_S1RL:
            begin
                sq_go = 1'b1; sq_val = acc_reg; sq_pairs = 6'd27;
            end
            S_TL, S_BTL:
            begin
                div_go = (usg_reg != 41'd0); div_num = acc_reg;
                div_den = 64'(usg_reg); div_bits = 7'd44;
            end
            S_AL:
            begin
                div_go = 1'b1; div_num = 64'(ah_reg) << FRAC_BITS;
                div_den = 64'(c0_plus_t); div_bits = 7'd33;
            end
            S_HRL:
            begin
                div_go = (25'(len_eff) > hmag); div_num = 64'(hmag) << FRAC_BITS;
                div_den = 64'(len_eff); div_bits = 7'd41;
            end
            S_BGL:
            begin
                div_go = 1'b1; div_num = 64'(ah_reg) << FRAC_BITS;
                div_den = 64'(K115 - t_reg[16:0]); div_bits = 7'd33;
            end
            default: ;
        endcase
    end

    // Restoring divider step: one quotient bit per cycle.
    assign div_rem_sh = {div_rem_reg[62:0], div_dq_reg[63]};
    assign div_qbit   = (div_rem_sh >= div_dvs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= 7'd0;
        end
        else if (div_go)
        begin
            div_cnt_reg <= div_bits;
        end
        else if (div_cnt_reg != 7'd0)
        begin
            div_cnt_reg <= div_cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_go)
        begin
            div_dq_reg  <= div_num << (7'd64 - div_bits);
            div_rem_reg <= 64'd0;
            div_dvs_reg <= div_den;
        end
        else if (div_cnt_reg != 7'd0)
        begin
            div_rem_reg <= div_qbit ? (div_rem_sh - div_dvs_reg) : div_rem_sh;
            div_dq_reg  <= {div_dq_reg[62:0], div_qbit};
        end
    end

    // Square root step: one root bit per cycle from two radicand bits.
    assign sq_rem_sh = {sq_rem_reg[32:0], sq_val_reg[63:62]};
    assign sq_trial  = {1'b0, sq_root_reg, 2'b01};
    assign sq_take   = (sq_rem_sh >= sq_trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_cnt_reg <= 6'd0;
        end
        else if (sq_go)
        begin
            sq_cnt_reg <= sq_pairs;
        end
        else if (sq_cnt_reg != 6'd0)
        begin
            sq_cnt_reg <= sq_cnt_reg - 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_go)
        begin
            sq_val_reg  <= sq_val << (7'd64 - {sq_pairs, 1'b0});
            sq_rem_reg  <= 35'd0;
            sq_root_reg <= 32'd0;
        end
        else if (sq_cnt_reg != 6'd0)
        begin
            sq_val_reg  <= {sq_val_reg[61:0], 2'b00};
            sq_rem_reg  <= sq_take ? (sq_rem_sh - sq_trial) : sq_rem_sh;
            sq_root_reg <= {sq_root_reg[30:0], sq_take};
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (item_taken && x_in != 17'd0) state_next = S_NUM;
            S_NUM:   state_next = S_DEN;
            S_DEN:   state_next = S_AHL;
            S_AHL:   state_next = S_AHW;
            S_AHW:   if (div_cnt_reg == 7'd0) state_next = S_UGM;
            S_UGM:   state_next = S_UGL;
            S_UGL:   state_next = S_UGW;
            S_UGW:   if (div_cnt_reg == 7'd0) state_next = S_SGG;
            S_SGG:   state_next = S_SGD;
            S_SGD:   state_next = S_S2L;
            S_S2L:   state_next = S_S2W;
            S_S2W:   if (sq_cnt_reg == 6'd0) state_next = S_S2DL;
            S_S2DL:  state_next = S_S2DW;
            S_S2DW:  if (div_cnt_reg == 7'd0) state_next = S_S2RL;
            S_S2RL:  state_next = S_S2RW;
            S_S2RW:
            begin
                if (sq_cnt_reg == 6'd0)
                begin
                    state_next = height_reg[24] ? S_HRL : S_AFL;
                end
            end
            S_AFL:   state_next = (26'(len_eff) > h2) ? S_AFW : S_K;
            S_AFW:   if (div_cnt_reg == 7'd0) state_next = S_K;
            S_K:     state_next = S_S1M;
            S_S1M:   state_next = S_S1L;
            S_S1L:   state_next = S_S1W;
            S_S1W:   if (sq_cnt_reg == 6'd0) state_next = S_S1P;
            S_S1P:   state_next = S_S1DL;
            S_S1DL:  state_next = S_S1DW;
            S_S1DW:  if (div_cnt_reg == 7'd0) state_next = S_S1RL;
            S_S1RL:  state_next = S_S1RW;
            S_S1RW:  if (sq_cnt_reg == 6'd0) state_next = S_C0A;
            S_C0A:   state_next = S_C0B;
            S_C0B:   state_next = S_VRA;
            S_VRA:   state_next = S_VRB;
            S_VRB:   state_next = S_TM;
            S_TM:    state_next = S_TL;
            S_TL:    state_next = (usg_reg != 41'd0) ? S_TW : S_CLAMP;
            S_TW:    if (div_cnt_reg == 7'd0) state_next = S_AL;
            S_AL:    state_next = S_AW;
            S_AW:
            begin
                if (div_cnt_reg == 7'd0)
                begin
                    if (div_dq_reg >= 64'(QUARTER_F) && !second_reg)
                    begin
                        state_next = S_C0S;
                    end
                    else
                    begin
                        state_next = S_CLAMP;
                    end
                end
            end
            S_C0S:   state_next = S_AL;
            S_CLAMP: state_next = S_FIN;
            S_HRL:   state_next = (25'(len_eff) > hmag) ? S_HRW : S_BM;
            S_HRW:   if (div_cnt_reg == 7'd0) state_next = S_BM;
            S_BM:    state_next = S_BB;
            S_BB:    state_next = S_BC;
            S_BC:    state_next = S_BD;
            S_BD:    state_next = S_BTL;
            S_BTL:   state_next = (usg_reg != 41'd0) ? S_BTW : S_BCHK;
            S_BTW:
            begin
                if (div_cnt_reg == 7'd0)
                begin
                    state_next = (div_dq_reg >= 64'(K115)) ? S_BCHK : S_BGL;
                end
            end
            S_BGL:   state_next = S_BGW;
            S_BGW:   if (div_cnt_reg == 7'd0) state_next = S_BCHK;
            S_BCHK:
            begin
                if ((diff < BISECT_TOL && diff > -BISECT_TOL) ||
                    (step_reg + STEP_W'(1) == STEP_LAST))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_BM;
                end
            end
            S_FIN:   state_next = S_DM1;
            S_DM1:   state_next = S_DM2;
            S_DM2:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            second_reg <= 1'b0;
            step_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_DM2) ||
                         (state_reg == S_IDLE && item_taken && x_in == 17'd0);
            if (state_reg == S_TL)
            begin
                second_reg <= 1'b0;
            end
            else if (state_reg == S_C0S)
            begin
                second_reg <= 1'b1;
            end
            if (state_reg == S_HRL)
            begin
                step_reg <= '0;
            end
            else if (state_reg == S_BCHK)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    // Datapath registers, loaded as the sequencer walks through the steps.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (item_taken)
                begin
                    x_reg   <= x_in;
                    rw_reg  <= rw_in;
                    rs_reg  <= rs_in;
                    sig_reg <= surface_tension;
                    if (x_in == 17'd0)
                    begin
                        void_out_reg  <= 17'd0;
                        dens_out_reg  <= rw_in;
                        homog_out_reg <= 1'b0;
                    end
                end
            end
            S_NUM:  num_reg <= prod[37:0];
            S_DEN:  den_reg <= num_reg + prod[37:0];
            S_AHW:  ah_reg <= div_dq_reg[16:0];
            S_UGM:  acc_reg <= prod[63:0];
            S_UGW:  usg_reg <= div_dq_reg[40:0];
            S_SGG:  acc_reg <= 64'(prod[67:8]);
            S_SGD:  acc_reg <= prod[63:0];
            S_S2W:  s2_reg <= sq_root_reg[27:0];
            S_S2DW: acc_reg <= div_dq_reg;
            S_S2RW: s2_reg <= sq_root_reg[27:0];
            S_AFL:  ratio_reg <= ONE_F;
            S_AFW:  ratio_reg <= div_dq_reg[16:0];
            S_K:    k_reg <= K012 + prod[32:16];
            S_S1M:  acc_reg <= prod[63:0];
            S_S1W:  s1_reg <= sq_root_reg[27:0];
            S_S1P:  acc_reg <= {prod[51:0], 12'd0};
            S_S1DW: acc_reg <= div_dq_reg;
            S_S1RW: s1_reg <= sq_root_reg[27:0];
            S_C0A:  acc_reg <= 64'(prod[67:16]);
            S_C0B:  c0_reg <= 27'(ONE_F) + prod[42:16];
            S_VRA:  acc_reg <= 64'(prod[67:16]);
            S_VRB:  vr_reg <= prod[42:16];
            S_TM:   acc_reg <= prod[63:0];
            S_TL:   a_reg <= 17'd0;
            S_TW:   t_reg <= div_dq_reg[43:0];
            S_AW:   a_reg <= div_dq_reg[16:0];
            S_C0S:  c0_reg <= 27'(ONE_F) + 27'(prod[32:16]);
            S_CLAMP: av_reg <= signed'({2'b00, a_clamp});
            S_HRL:
            begin
                ratio_reg <= ONE_F;
                lo_reg    <= x_reg;
                hi_reg    <= VOID_HIGH;
            end
            S_HRW:  ratio_reg <= div_dq_reg[16:0];
            S_BM:
            begin
                m_reg   <= m_now;
                acc_reg <= 64'(prod[67:16]);
            end
            S_BB:   acc_reg <= 64'(prod[67:16]);
            S_BC:   vr_reg <= prod[42:16];
            S_BD:   acc_reg <= prod[63:0];
            S_BTL:  av_reg <= -19'sd1;
            S_BTW:
            begin
                t_reg <= div_dq_reg[43:0];
                if (div_dq_reg > 64'(K115))
                begin
                    av_reg <= -19'sd1;
                end
                else if (div_dq_reg == 64'(K115))
                begin
                    av_reg <= signed'({1'b0, ONE_F, 1'b0});
                end
            end
            S_BGW:
            begin
                if (div_dq_reg > 64'({ONE_F, 1'b0}))
                begin
                    av_reg <= signed'({1'b0, ONE_F, 1'b0});
                end
                else
                begin
                    av_reg <= signed'({1'b0, div_dq_reg[17:0]});
                end
            end
            S_BCHK:
            begin
                if (diff > 20'sd0)
                begin
                    hi_reg <= m_reg;
                end
                else
                begin
                    lo_reg <= m_reg;
                end
            end
            S_FIN:
            begin
                if (av_reg < signed'({2'b00, x_reg}) || av_reg > signed'({2'b00, VOID_HIGH}))
                begin
                    afin_reg <= ah_reg;
                    flag_reg <= 1'b1;
                end
                else
                begin
                    afin_reg <= av_reg[16:0];
                    flag_reg <= 1'b0;
                end
            end
            S_DM1:  acc_reg <= prod[63:0];
            S_DM2:
            begin
                void_out_reg  <= afin_reg;
                dens_out_reg  <= 20'((acc_reg + prod[63:0] + 64'(HALF_F)) >> FRAC_BITS);
                homog_out_reg <= flag_reg;
            end
            default: ;
        endcase
    end

endmodule

// File: src/vfmd_checker.sv
// Port-level checker for the void fraction core and the bind that attaches it.
`timescale 1ns / 1ps

module vfmd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [16:0] void_fraction
);
    import vfmd_pkg::*;

    // A result is only delivered once the core has gone back to idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result transfer while the core is still busy");

    // Leaving the busy phase always delivers a result.
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> done)
        else $error("core went idle without a result transfer");

    // An accepted item either starts work or finishes at once.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> (busy || done))
        else $error("accepted item was dropped");

    // The void fraction never exceeds one.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> (void_fraction <= VOID_MAX_OUT))
        else $error("void fraction above one");

endmodule

bind void_fraction_mixture_density_core vfmd_checker u_vfmd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .void_fraction (void_fraction)
);

// File: tb/void_fraction_mixture_density_core_tb.sv
// Testbench for the void fraction and mixture density core, with its own bit-exact predictor.
`timescale 1ns / 1ps

module void_fraction_mixture_density_core_tb;
    import vfmd_pkg::*;

    typedef longint unsigned u64;

    // One result of the core.
    typedef struct packed {
        logic [16:0] void_frac;
        logic [19:0] mix_dens;
        logic        homog;
    } vf_result_t;

    // Holds the results still owed by the core and compares each one as it comes out.
    class density_scoreboard;
        vf_result_t owed[$];
        int         errors;
        int         matched;

        function void note(vf_result_t r);
            owed.push_back(r);
        endfunction

        function void check(vf_result_t got);
            vf_result_t want;
            if (owed.size() == 0)
            begin
                $display("%0t: result with none owed: void %0d dens %0d flag %0d",
                         $time, got.void_frac, got.mix_dens, got.homog);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.void_frac !== want.void_frac)
            begin
                $display("%0t: void_fraction expected %0d actual %0d",
                         $time, want.void_frac, got.void_frac);
                errors++;
            end
            if (got.mix_dens !== want.mix_dens)
            begin
                $display("%0t: mixture_density expected %0d actual %0d",
                         $time, want.mix_dens, got.mix_dens);
                errors++;
            end
            if (got.homog !== want.homog)
            begin
                $display("%0t: used_homogeneous expected %0d actual %0d",
                         $time, want.homog, got.homog);
                errors++;
            end
            matched++;
        endfunction
    endclass

    localparam int BISECT_LIMIT = 50;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = REG_HEIGHT;
    logic [24:0] cfg_data = '0;
    logic        start = 1'b0;
    logic        busy;
    logic [16:0] quality = '0;
    logic [19:0] water_density = '0;
    logic [19:0] steam_density = '0;
    logic [23:0] surface_tension = '0;
    logic        done;
    logic [16:0] void_fraction;
    logic [19:0] mixture_density;
    logic        used_homogeneous;

    // Shadow copy of the section registers.
    longint section_height = 0;
    u64     section_length = 65536;
    u64     tube_diam = 838861;
    u64     mass_vel = 256000;

    density_scoreboard sb = new();
    int  items_sent;
    int  down_items;
    bit  idle_enable;

    void_fraction_mixture_density_core u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .quality(quality),
        .water_density(water_density), .steam_density(steam_density),
        .surface_tension(surface_tension), .done(done), .void_fraction(void_fraction),
        .mixture_density(mixture_density), .used_homogeneous(used_homogeneous)
    );

    always #4 clk = ~clk;

    // Floor integer square root.
    function automatic u64 int_root(u64 v);
        u64 r;
        u64 b;
        r = 0;
        b = u64'(1) << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Drift-flux void for upward flow.
    function automatic u64 rising_void(u64 c0, u64 vr, u64 ah, u64 usg);
        u64 t;
        if (usg == 0)
            return 0;
        t = vr * ah / usg;
        return (ah << FRAC_BITS) / (c0 + t);
    endfunction

    // One evaluation of the downward-flow fixed point map.
    function automatic longint falling_guess(u64 m, u64 ah, u64 s2, u64 hr, u64 usg);
        u64 one;
        u64 vr;
        u64 t;
        u64 g;
        one = u64'(ONE_F);
        if (m > one)
            m = one;
        vr = (((((one - m) * s2) >> FRAC_BITS) * hr) >> FRAC_BITS) * u64'(K153_Q16) >> 16;
        if (usg == 0)
            return -1;
        t = vr * ah / usg;
        if (t > u64'(K115))
            return -1;
        if (t == u64'(K115))
            return longint'(2 * one);
        g = (ah << FRAC_BITS) / (u64'(K115) - t);
        if (g > 2 * one)
            g = 2 * one;
        return longint'(g);
    endfunction

    // Expected void fraction and mixture density for one fluid state.
    function automatic vf_result_t predict_density(logic [16:0] q, logic [19:0] wd,
                                                   logic [19:0] sd, logic [23:0] st);
        vf_result_t res;
        u64 one, x, rw, rs, sig, len, dia, gm;
        u64 num, den, ah, usg, drho, s2, a;
        u64 h2, af, k, s1, c0, vr, hmag, hr, lo, hi, m;
        longint av, diff;
        bit flag;
        one = u64'(ONE_F);
        x = q;
        rw = wd;
        rs = sd;
        sig = st;
        len = section_length ? section_length : 1;
        dia = tube_diam ? tube_diam : 1;
        gm = mass_vel ? mass_vel : 1;
        flag = 1'b0;
        if (x > one)
            x = one;
        if (rw == 0)
            rw = 1;
        if (rs == 0)
            rs = 1;
        if (x == 0)
        begin
            res.void_frac = '0;
            res.mix_dens = rw[19:0];
            res.homog = 1'b0;
            return res;
        end

        num = rw * x;
        den = num + rs * (one - x);
        ah = (num << FRAC_BITS) / den;
        usg = x * gm / rs;
        drho = (rw > rs) ? rw - rs : 0;
        s2 = int_root(((sig * u64'(GRAV_Q16)) >> 8) * drho);
        s2 = int_root((s2 << 20) / rw);

        if (section_height >= 0)
        begin
            // Upward or level: drift flux with inclination factor, flat-C0 retry, then clamp.
            h2 = 2 * u64'(section_height);
            af = (h2 >= len) ? one : (h2 << FRAC_BITS) / len;
            k = u64'(K012) + ((u64'(K008) * af) >> FRAC_BITS);
            s1 = int_root(dia * u64'(GRAV_Q16));
            s1 = int_root(((s1 * rw) << 12) / gm);
            c0 = one + ((((k * (one - x)) >> FRAC_BITS) * s1) >> 16);
            vr = ((((one - x) * s2) >> FRAC_BITS) * u64'(K118_Q16)) >> 16;
            a = rising_void(c0, vr, ah, usg);
            if (a >= one / 4)
            begin
                c0 = one + (((one - x) * u64'(K020)) >> FRAC_BITS);
                a = rising_void(c0, vr, ah, usg);
            end
            if (a < x)
                a = x;
            if (a > ah)
                a = ah;
            av = longint'(a);
        end
        else
        begin
            // Downward: bisect the fixed point between quality and just under one.
            hmag = u64'(-section_height);
            hr = (hmag >= len) ? one : (hmag << FRAC_BITS) / len;
            lo = x;
            hi = u64'(VOID_HIGH);
            av = 0;
            for (int i = 0; i < BISECT_LIMIT; i++)
            begin
                m = (lo + hi) >> 1;
                av = falling_guess(m, ah, s2, hr, usg);
                diff = longint'(m) - av;
                if (diff < 1 && diff > -1)
                    break;
                if (diff > 0)
                    hi = m;
                else
                    lo = m;
            end
        end

        // Fall back to the homogeneous void when out of range.
        if (av < longint'(x) || av > longint'(VOID_HIGH))
        begin
            av = longint'(ah);
            flag = 1'b1;
        end
        a = u64'(av);
        res.void_frac = a[16:0];
        res.mix_dens = 20'((rw * (one - a) + rs * a + (one >> 1)) >> FRAC_BITS);
        res.homog = flag;
        return res;
    endfunction

    // Result monitor; the core cannot be stalled, so every done cycle is a transfer.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check({void_fraction, mixture_density, used_homogeneous});
    end

    // Waits until every owed result has come and the core is idle.
    task automatic drain();
        while (sb.owed.size() != 0 || busy)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    // Writes one section register while the core is idle.
    task automatic write_section(logic [1:0] idx, logic [24:0] val);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_write = 1'b0;
        case (idx)
            REG_HEIGHT:   section_height = longint'(signed'(val));
            REG_LENGTH:   section_length = val[23:0];
            REG_DIAMETER: tube_diam = val[23:0];
            default:      mass_vel = val[23:0];
        endcase
    endtask

    task automatic set_section(logic [24:0] h, logic [23:0] l, logic [23:0] d, logic [23:0] g);
        drain();
        write_section(REG_HEIGHT, h);
        write_section(REG_LENGTH, {1'b0, l});
        write_section(REG_DIAMETER, {1'b0, d});
        write_section(REG_MASSVEL, {1'b0, g});
    endtask

    // Presents one fluid state and holds it until the core takes the transfer.
    task automatic send_state(logic [16:0] q, logic [19:0] wd, logic [19:0] sd,
                              logic [23:0] st);
        if (idle_enable)
        begin
            while ($urandom_range(99) < 18)
                @(negedge clk);
        end
        quality = q;
        water_density = wd;
        steam_density = sd;
        surface_tension = st;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note(predict_density(q, wd, sd, st));
        items_sent++;
        if (section_height < 0)
            down_items++;
        @(negedge clk);
        start = 1'b0;
    endtask

    // Random fluid state: mostly physical values, some raw noise over the full fields.
    task automatic send_random();
        logic [16:0] q;
        logic [19:0] wd;
        logic [19:0] sd;
        logic [23:0] st;
        if ($urandom_range(99) < 20)
        begin
            q = 17'($urandom());
            wd = 20'($urandom());
            sd = 20'($urandom());
            st = 24'($urandom());
        end
        else
        begin
            q = 17'($urandom_range(65536, 1));
            wd = 20'($urandom_range(256 * 1000, 256 * 500));
            sd = 20'($urandom_range(256 * 200, 64));
            st = 24'($urandom_range(1000000, 10000));
        end
        send_state(q, wd, sd, st);
    endtask

    task automatic random_section();
        logic [24:0] h;
        if ($urandom_range(3) == 0)
            h = 25'($urandom());
        else
            h = 25'($signed($urandom_range(131072 * 2)) - 131072);
        set_section(h, 24'($urandom_range(16777215, 1) >> $urandom_range(8)),
                    24'($urandom_range(16777215, 1) >> $urandom_range(8)),
                    24'($urandom_range(16777215, 1) >> $urandom_range(8)));
    endtask

    initial
    begin
        #80_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        idle_enable = 1'b1;

        // Directed states at the reset geometry (level section).
        send_state(17'd0, 20'd200000, 20'd5000, 24'd500000);
        send_state(17'd65536, 20'd200000, 20'd5000, 24'd500000);
        send_state(17'd131071, 20'd200000, 20'd5000, 24'd500000);
        send_state(17'd1, 20'd1048575, 20'd1, 24'd16777215);
        send_state(17'd30000, 20'd5000, 20'd5000, 24'd0);
        send_state(17'd30000, 20'd5000, 20'd9000, 24'd300000);
        send_state(17'd100, 20'd0, 20'd0, 24'd300000);
        send_state(17'd1000, 20'd1048575, 20'd1048575, 24'd16777215);

        // Upward with ratio saturated, and the extremes of each register.
        set_section(25'd16777215, 24'd1, 24'd16777215, 24'd1);
        send_state(17'd40000, 20'd200000, 20'd2000, 24'd500000);
        send_state(17'd2, 20'd1048575, 20'd1, 24'd16777215);
        set_section(25'd0, 24'd0, 24'd0, 24'd0);
        send_state(17'd20000, 20'd200000, 20'd2000, 24'd500000);
        set_section(25'd30000, 24'd16777215, 24'd1, 24'd16777215);
        send_state(17'd65535, 20'd200000, 20'd10000, 24'd500000);
        send_state(17'd500, 20'd200000, 20'd10000, 24'd500000);

        // Downward sections: most negative height, then a mild slope.
        set_section(25'h1000000, 24'd65536, 24'd838861, 24'd256000);
        send_state(17'd5000, 20'd200000, 20'd5000, 24'd500000);
        send_state(17'd65536, 20'd200000, 20'd5000, 24'd500000);
        send_state(17'd10, 20'd250000, 20'd100, 24'd16777215);
        set_section(-25'sd20000, 24'd65536, 24'd838861, 24'd1);
        send_state(17'd5000, 20'd200000, 20'd5000, 24'd500000);
        send_state(17'd50000, 20'd200000, 20'd5000, 24'd0);

        // Random phases; one phase runs with no sender gaps.
        for (int ph = 0; ph < 8; ph++)
        begin
            random_section();
            idle_enable = (ph != 3);
            for (int n = 0; n < 60; n++)
                send_random();
        end

        drain();
        repeat (20) @(posedge clk);
        $display("Sent %0d fluid states (%0d on downward sections), %0d results compared.",
                 items_sent, down_items, sb.matched);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
